/* sv/hlpd_pkg.sv */
// Shared types and constants of the handshake length-prefix deframer.
package hlpd_pkg;

  localparam int CONNECTIONS_DEF = 256;
  localparam int LENGTH_BITS_DEF = 24;

  // per-connection header assembly fields
  localparam int ST_W    = 3;
  localparam int CNT_W   = 2;
  localparam int SHIFT_W = 24;

  typedef enum logic [1:0] {
    OP_DATA    = 2'd0,
    OP_OPEN_HS = 2'd1,
    OP_OPEN_OK = 2'd2,
    OP_DOWN    = 2'd3
  } opcode_t;

  typedef enum logic [ST_W-1:0] {
    ST_WAIT      = 3'd0,
    ST_HANDSHAKE = 3'd1,
    ST_HEADER    = 3'd2,
    ST_CONNECT   = 3'd3,
    ST_DOWN      = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_HELLO   = 2'd2,
    KIND_ERROR   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_MISMATCH = 3'd1,
    ERR_TOO_LONG = 3'd2,
    ERR_NOT_OPEN = 3'd3,
    ERR_ALREADY  = 3'd4
  } err_t;

  typedef struct packed {
    logic       valid;
    kind_t      kind;
    logic [7:0] conn;
    logic [7:0] payload;
    logic       last;
    err_t       err;
  } result_t;

endpackage

/* sv/hlpd_if.sv */
// Valid/ready channel interfaces for the deframer input and result words.
interface hlpd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] connection;
  logic [7:0] data_byte;

  modport source (output valid, output opcode, output connection, output data_byte,
                  input ready);
  modport sink (input valid, input opcode, input connection, input data_byte,
                output ready);
endinterface

interface hlpd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] out_connection;
  logic [7:0] payload_byte;
  logic       frame_last;
  logic [2:0] error_code;

  modport source (output valid, output kind, output out_connection, output payload_byte,
                  output frame_last, output error_code, input ready);
  modport sink (input valid, input kind, input out_connection, input payload_byte,
                input frame_last, input error_code, output ready);
endinterface

/* sv/hlpd_state_mem.sv */
// Per-connection state memory: clearing sweep after reset, write-to-read bypass.
module hlpd_state_mem #(
  parameter int DEPTH = hlpd_pkg::CONNECTIONS_DEF,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  output logic                     busy
);

  localparam int IDX_W = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_q;
  logic             byp;
  logic [WIDTH-1:0] byp_data;
  logic             clearing;
  logic [IDX_W-1:0] clr_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      if (clr_idx == IDX_W'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end
      clr_idx <= clr_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_idx] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // same-edge write to the entry being read: take the new data
  always_ff @(posedge clk) begin
    if (rst) begin
      byp <= 1'b0;
    end else if (rd_en) begin
      byp <= wr_en && (wr_addr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      byp_data <= wr_data;
    end
  end

  assign rd_data = byp ? byp_data : rd_q;
  assign busy    = clearing;

endmodule

/* sv/hlpd_update.sv */
// Read-modify-write step: new connection state and result from one input word.
module hlpd_update #(
  parameter int LENGTH_BITS = hlpd_pkg::LENGTH_BITS_DEF
) (
  input  hlpd_pkg::opcode_t                op,
  input  logic [7:0]                       conn,
  input  logic [7:0]                       data,
  input  logic                             in_range,
  input  hlpd_pkg::status_t                st_cur,
  input  logic [hlpd_pkg::CNT_W-1:0]       cnt_cur,
  input  logic [hlpd_pkg::SHIFT_W-1:0]     shift_cur,
  input  logic [LENGTH_BITS-1:0]           remain_cur,
  output logic                             we,
  output hlpd_pkg::status_t                st_new,
  output logic [hlpd_pkg::CNT_W-1:0]       cnt_new,
  output logic [hlpd_pkg::SHIFT_W-1:0]     shift_new,
  output logic [LENGTH_BITS-1:0]           remain_new,
  output hlpd_pkg::result_t                res
);

  logic [31:0]            full;
  logic [LENGTH_BITS-1:0] len;

  assign full = {shift_cur, data};
  assign len  = full[LENGTH_BITS-1:0];

  always_comb begin
    we          = 1'b0;
    st_new      = st_cur;
    cnt_new     = cnt_cur;
    shift_new   = shift_cur;
    remain_new  = remain_cur;
    res.valid   = 1'b0;
    res.kind    = hlpd_pkg::KIND_PAYLOAD;
    res.conn    = conn;
    res.payload = 8'd0;
    res.last    = 1'b0;
    res.err     = hlpd_pkg::ERR_NONE;

    if (!in_range) begin
      if (op == hlpd_pkg::OP_DATA) begin
        res.valid = 1'b1;
        res.kind  = hlpd_pkg::KIND_ERROR;
        res.err   = hlpd_pkg::ERR_NOT_OPEN;
      end
    end else begin
      case (op)
        hlpd_pkg::OP_OPEN_HS, hlpd_pkg::OP_OPEN_OK: begin
          if (st_cur != hlpd_pkg::ST_WAIT) begin
            res.valid = 1'b1;
            res.kind  = hlpd_pkg::KIND_ERROR;
            res.err   = hlpd_pkg::ERR_ALREADY;
          end else begin
            we         = 1'b1;
            st_new     = (op == hlpd_pkg::OP_OPEN_HS) ? hlpd_pkg::ST_HANDSHAKE
                                                      : hlpd_pkg::ST_HEADER;
            cnt_new    = '0;
            shift_new  = '0;
            remain_new = '0;
          end
        end
        hlpd_pkg::OP_DOWN: begin
          we     = 1'b1;
          st_new = hlpd_pkg::ST_DOWN;
        end
        default: begin
          case (st_cur)
            hlpd_pkg::ST_HANDSHAKE: begin
              we        = 1'b1;
              res.valid = 1'b1;
              if (data != conn) begin
                st_new   = hlpd_pkg::ST_DOWN;
                res.kind = hlpd_pkg::KIND_ERROR;
                res.err  = hlpd_pkg::ERR_MISMATCH;
              end else begin
                st_new     = hlpd_pkg::ST_HEADER;
                cnt_new    = '0;
                shift_new  = '0;
                remain_new = '0;
                res.kind   = hlpd_pkg::KIND_HELLO;
              end
            end
            hlpd_pkg::ST_HEADER: begin
              we = 1'b1;
              if (cnt_cur != hlpd_pkg::CNT_W'(3)) begin
                cnt_new   = cnt_cur + 1'b1;
                shift_new = {shift_cur[15:0], data};
              end else begin
                cnt_new   = '0;
                shift_new = '0;
                if ((full >> LENGTH_BITS) != 32'd0) begin
                  st_new    = hlpd_pkg::ST_DOWN;
                  res.valid = 1'b1;
                  res.kind  = hlpd_pkg::KIND_ERROR;
                  res.err   = hlpd_pkg::ERR_TOO_LONG;
                end else if (len == '0) begin
                  remain_new = '0;
                  res.valid  = 1'b1;
                  res.kind   = hlpd_pkg::KIND_EMPTY;
                  res.last   = 1'b1;
                end else begin
                  st_new     = hlpd_pkg::ST_CONNECT;
                  remain_new = len;
                end
              end
            end
            hlpd_pkg::ST_CONNECT: begin
              we          = 1'b1;
              res.valid   = 1'b1;
              res.kind    = hlpd_pkg::KIND_PAYLOAD;
              res.payload = data;
              if (remain_cur == LENGTH_BITS'(1)) begin
                res.last   = 1'b1;
                st_new     = hlpd_pkg::ST_HEADER;
                cnt_new    = '0;
                shift_new  = '0;
                remain_new = '0;
              end else begin
                remain_new = remain_cur - 1'b1;
              end
            end
            default: begin
              res.valid = 1'b1;
              res.kind  = hlpd_pkg::KIND_ERROR;
              res.err   = hlpd_pkg::ERR_NOT_OPEN;
            end
          endcase
        end
      endcase
    end
  end

endmodule

/* sv/handshake_length_prefix_deframer.sv */
// Top level of the per-connection handshake and length-prefix deframer.
//
// Takes one word per clock from any mix of connections, except during the reset sweep
// or while a full output register waits, and gives at most one result word per input
// word. Each connection's state (status, header byte count, partial length, bytes left
// in the frame) sits in one CONNECTIONS-deep memory with a synchronous read: the read
// is issued as the word is accepted, update and write-back happen as it leaves stage
// 1, and a word that hits the connection written on that same edge picks up the new
// entry through a bypass, so back-to-back words on one connection need no stall.
// Results go into an output register; the input keeps flowing while it is taken. After
// reset the memory is swept to the wait state, one entry per cycle. Lengths are
// big-endian 4-byte prefixes; bits above LENGTH_BITS must be zero.
module handshake_length_prefix_deframer #(
  parameter int CONNECTIONS = hlpd_pkg::CONNECTIONS_DEF,
  parameter int LENGTH_BITS = hlpd_pkg::LENGTH_BITS_DEF
) (
  input logic          clk,
  input logic          rst,
  hlpd_in_if.sink      stream,
  hlpd_out_if.source   result
);

  localparam int IDX_W   = $clog2(CONNECTIONS);
  localparam int ENTRY_W = hlpd_pkg::ST_W + hlpd_pkg::CNT_W + hlpd_pkg::SHIFT_W + LENGTH_BITS;

  // stage 1: word whose state entry is being read
  logic              s1_valid;
  hlpd_pkg::opcode_t s1_op;
  logic [7:0]        s1_conn;
  logic [7:0]        s1_byte;
  logic              s1_in_range;
  logic              s1_go;
  logic              accept;

  // memory ports
  logic               busy;
  logic [ENTRY_W-1:0] rd_data;
  logic [ENTRY_W-1:0] wr_data;
  logic               wr_en;

  // unpacked entry, old and new
  logic [hlpd_pkg::ST_W-1:0]      st_bits;
  hlpd_pkg::status_t              st_cur;
  logic [hlpd_pkg::CNT_W-1:0]     cnt_cur;
  logic [hlpd_pkg::SHIFT_W-1:0]   shift_cur;
  logic [LENGTH_BITS-1:0]         remain_cur;
  hlpd_pkg::status_t              st_new;
  logic [hlpd_pkg::CNT_W-1:0]     cnt_new;
  logic [hlpd_pkg::SHIFT_W-1:0]   shift_new;
  logic [LENGTH_BITS-1:0]         remain_new;
  logic                           upd_we;
  hlpd_pkg::result_t              upd_res;

  // output register
  logic              out_valid;
  hlpd_pkg::result_t out_q;

  // stage 1 moves on whenever the output register is free or being emptied
  assign s1_go        = s1_valid && (!out_valid || result.ready);
  assign stream.ready = !busy && (!s1_valid || s1_go);
  assign accept       = stream.valid && stream.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op       <= hlpd_pkg::opcode_t'(stream.opcode);
      s1_conn     <= stream.connection;
      s1_byte     <= stream.data_byte;
      s1_in_range <= (32'(stream.connection) < CONNECTIONS);
    end
  end

  assign {st_bits, cnt_cur, shift_cur, remain_cur} = rd_data;
  assign st_cur = hlpd_pkg::status_t'(st_bits);

  hlpd_update #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_update (
    .op         (s1_op),
    .conn       (s1_conn),
    .data       (s1_byte),
    .in_range   (s1_in_range),
    .st_cur     (st_cur),
    .cnt_cur    (cnt_cur),
    .shift_cur  (shift_cur),
    .remain_cur (remain_cur),
    .we         (upd_we),
    .st_new     (st_new),
    .cnt_new    (cnt_new),
    .shift_new  (shift_new),
    .remain_new (remain_new),
    .res        (upd_res)
  );

  assign wr_en   = s1_go && upd_we;
  assign wr_data = {st_new, cnt_new, shift_new, remain_new};

  hlpd_state_mem #(
    .DEPTH (CONNECTIONS),
    .WIDTH (ENTRY_W)
  ) u_state_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (IDX_W'(stream.connection)),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (IDX_W'(s1_conn)),
    .wr_data (wr_data),
    .busy    (busy)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go) begin
      out_valid <= upd_res.valid;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && upd_res.valid) begin
      out_q <= upd_res;
    end
  end

  assign result.valid          = out_valid;
  assign result.kind           = out_q.kind;
  assign result.out_connection = out_q.conn;
  assign result.payload_byte   = out_q.payload;
  assign result.frame_last     = out_q.last;
  assign result.error_code     = out_q.err;

`ifndef SYNTH
  // error code is none on every non-error word
  a_err_code: assert property (@(posedge clk) disable iff (rst)
    result.valid && (result.kind != hlpd_pkg::KIND_ERROR) |->
      result.error_code == hlpd_pkg::ERR_NONE)
    else $error("error code on a non-error word");

  // frame end only on payload or empty frame
  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.frame_last |->
      (result.kind == hlpd_pkg::KIND_PAYLOAD) || (result.kind == hlpd_pkg::KIND_EMPTY))
    else $error("frame end on a word that is not part of a frame");

  // no state write-back while the clearing sweep owns the memory
  a_no_write_clear: assert property (@(posedge clk) disable iff (rst)
    busy |-> !wr_en)
    else $error("state write during clearing sweep");

  // an accepted word always lands in stage 1
  a_accept_s1: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted word lost before update");
`endif

endmodule

/* bench/deframe_checker.sv */
// Watches both deframer channels, predicts each result word and compares it on arrival.
module deframe_checker
  import hlpd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  hlpd_in_if   stream,
  hlpd_out_if  result,
  output int   fail_count,
  output int   pending
);

  typedef struct packed {
    kind_t      kind;
    logic [7:0] conn;
    logic [7:0] payload;
    logic       last;
    err_t       err;
  } outcome_t;

  localparam int REPORT_LIMIT = 10;

  // per-connection copy of the deframer state
  status_t     link_state [CONNECTIONS_DEF];
  logic [31:0] len_shift  [CONNECTIONS_DEF];
  logic [23:0] byte_count [CONNECTIONS_DEF];
  logic [23:0] frame_len  [CONNECTIONS_DEF];

  outcome_t    due_results [$];
  int          mismatches  = 0;
  int          outstanding = 0;

  assign fail_count = mismatches;
  assign pending    = outstanding;

  // Advances the state for one accepted word; returns 1 when a result word is due.
  function automatic bit deframe_word(input opcode_t op, input logic [7:0] c,
                                      input logic [7:0] b, output outcome_t res);
    bit made;
    made = 1'b0;
    res  = '{kind: KIND_ERROR, conn: c, payload: 8'd0, last: 1'b0, err: ERR_NONE};
    case (op)
      OP_OPEN_HS, OP_OPEN_OK: begin
        if (link_state[c] != ST_WAIT) begin
          res.err = ERR_ALREADY;
          made    = 1'b1;
        end else begin
          len_shift[c]  = 32'd0;
          byte_count[c] = 24'd0;
          frame_len[c]  = 24'd0;
          link_state[c] = (op == OP_OPEN_HS) ? ST_HANDSHAKE : ST_HEADER;
        end
      end
      OP_DOWN: link_state[c] = ST_DOWN;
      default: begin
        made = 1'b1;
        case (link_state[c])
          ST_HANDSHAKE: begin
            if (b != c) begin
              link_state[c] = ST_DOWN;
              res.err       = ERR_MISMATCH;
            end else begin
              link_state[c] = ST_HEADER;
              len_shift[c]  = 32'd0;
              byte_count[c] = 24'd0;
              frame_len[c]  = 24'd0;
              res.kind      = KIND_HELLO;
            end
          end
          ST_HEADER: begin
            len_shift[c]  = {len_shift[c][23:0], b};
            byte_count[c] = (byte_count[c] + 24'd1) & 24'd7;
            if (byte_count[c] < 24'd4) begin
              made = 1'b0;
            end else if (len_shift[c][31:24] != 8'd0) begin
              link_state[c] = ST_DOWN;
              res.err       = ERR_TOO_LONG;
            end else begin
              frame_len[c]  = len_shift[c][23:0];
              len_shift[c]  = 32'd0;
              byte_count[c] = 24'd0;
              if (frame_len[c] == 24'd0) begin
                res.kind = KIND_EMPTY;
                res.last = 1'b1;
              end else begin
                link_state[c] = ST_CONNECT;
                made          = 1'b0;
              end
            end
          end
          ST_CONNECT: begin
            byte_count[c] = byte_count[c] + 24'd1;
            res.kind      = KIND_PAYLOAD;
            res.payload   = b;
            if (byte_count[c] >= frame_len[c]) begin
              len_shift[c]  = 32'd0;
              byte_count[c] = 24'd0;
              frame_len[c]  = 24'd0;
              link_state[c] = ST_HEADER;
              res.last      = 1'b1;
            end
          end
          default: res.err = ERR_NOT_OPEN;
        endcase
      end
    endcase
    return made;
  endfunction

  always @(posedge clk) begin
    outcome_t want;
    outcome_t seen;
    if (rst) begin
      for (int i = 0; i < CONNECTIONS_DEF; i++) begin
        link_state[i] = ST_WAIT;
        len_shift[i]  = 32'd0;
        byte_count[i] = 24'd0;
        frame_len[i]  = 24'd0;
      end
      due_results.delete();
    end else begin
      if (stream.valid && stream.ready) begin
        if (deframe_word(opcode_t'(stream.opcode), stream.connection, stream.data_byte, want))
          due_results.push_back(want);
      end
      if (result.valid && result.ready) begin
        seen = '{kind: kind_t'(result.kind), conn: result.out_connection,
                 payload: result.payload_byte, last: result.frame_last,
                 err: err_t'(result.error_code)};
        if (due_results.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("unexpected word: kind %0d conn %0d byte %h last %0d err %0d",
                     seen.kind, seen.conn, seen.payload, seen.last, seen.err);
        end else begin
          want = due_results.pop_front();
          if (seen !== want) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display({"mismatch: want kind %0d conn %0d byte %h last %0d err %0d, ",
                        "got kind %0d conn %0d byte %h last %0d err %0d"},
                       want.kind, want.conn, want.payload, want.last, want.err,
                       seen.kind, seen.conn, seen.payload, seen.last, seen.err);
          end
        end
      end
    end
    outstanding = due_results.size();
  end

endmodule

/* bench/testbench.sv */
// Bench top: clock, reset, stimulus words and verdict for the deframer.
module testbench;
  import hlpd_pkg::*;

  // one stimulus word as held in the session queues
  typedef struct packed {
    opcode_t    op;
    logic [7:0] conn;
    logic [7:0] data;
  } stream_word_t;

  localparam int RANDOM_WORDS = 1700;
  localparam int IDLE_PCT     = 27;   // chance in a hundred of an idle cycle, either side
  localparam int NOISE_PCT    = 8;    // stray words on random connections
  localparam int BACKLOG_MIN  = 12;   // refill threshold; keeps sessions interleaved

  logic clk = 1'b0;
  logic rst;
  int   fail_count;
  int   pending;
  bit   calm;                         // no idling on either side while set
  bit   spent [CONNECTIONS_DEF];      // connections already opened or taken down

  stream_word_t backlog [$];          // interleaved words still to be sent
  stream_word_t session [$];          // freshly planned session, not yet mixed in

  hlpd_in_if  stream ();
  hlpd_out_if result ();

  handshake_length_prefix_deframer DUT (
    .clk    (clk),
    .rst    (rst),
    .stream (stream),
    .result (result)
  );

  deframe_checker deframe_check (
    .clk        (clk),
    .rst        (rst),
    .stream     (stream),
    .result     (result),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #2 clk = ~clk;

  // Hard stop in case a handshake never completes.
  initial begin
    #2_000_000;
    $display("handshake_length_prefix_deframer test failed");
    $finish;
  end

  // Result side: ready drops at random, except during the calm stretch.
  initial begin
    result.ready <= 1'b0;
    forever begin
      @(posedge clk);
      result.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Offers one word, with random idle cycles in front, and returns just after the
  // edge at which it was taken. Valid is left high so back-to-back words stream.
  task automatic put_word(input opcode_t op, input logic [7:0] c, input logic [7:0] b);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      stream.valid <= 1'b0;
      @(posedge clk);
    end
    stream.valid      <= 1'b1;
    stream.opcode     <= op;
    stream.connection <= c;
    stream.data_byte  <= b;
    @(posedge clk);
    while (!stream.ready) @(posedge clk);
  endtask

  // 4-byte big-endian length prefix.
  task automatic put_header(input logic [7:0] c, input logic [31:0] len);
    put_word(OP_DATA, c, len[31:24]);
    put_word(OP_DATA, c, len[23:16]);
    put_word(OP_DATA, c, len[15:8]);
    put_word(OP_DATA, c, len[7:0]);
  endtask

  // Prefers a connection still in wait, so that sessions get past the open.
  function automatic logic [7:0] fresh_connection();
    logic [7:0] c;
    c = 8'($urandom);
    for (int i = 0; i < 64 && spent[c]; i++) c = 8'($urandom);
    spent[c] = 1'b1;
    return c;
  endfunction

  // Plans one session on connection c: open (with or without handshake), then a
  // few frames. Mostly short well-formed frames; now and then an empty frame, a
  // too-long prefix, or a huge length cut short by a mark down.
  function automatic void plan_session(input logic [7:0] c);
    int          frames;
    int          r;
    logic [23:0] len;
    logic [7:0]  top;
    bit          hs;
    hs = 1'($urandom_range(1));
    session.push_back('{hs ? OP_OPEN_HS : OP_OPEN_OK, c, 8'($urandom)});
    // the occasional handshake byte is off by one bit
    if (hs)
      session.push_back('{OP_DATA, c,
                          ($urandom_range(9) == 0) ? c ^ (8'd1 << $urandom_range(7)) : c});
    frames = $urandom_range(5, 1);
    for (int f = 0; f < frames; f++) begin
      r   = $urandom_range(99);
      top = 8'd0;
      if (r < 10) begin
        len = 24'd0;
      end else if (r < 15) begin
        top = 8'($urandom_range(255, 1));
        len = 24'($urandom);
      end else if (r < 20) begin
        len = ($urandom_range(2) == 0) ? 24'hFFFFFF : 24'($urandom_range(24'hFFFFFF, 24'h100));
      end else begin
        len = 24'($urandom_range(8, 1));
      end
      session.push_back('{OP_DATA, c, top});
      session.push_back('{OP_DATA, c, len[23:16]});
      session.push_back('{OP_DATA, c, len[15:8]});
      session.push_back('{OP_DATA, c, len[7:0]});
      if (top != 8'd0) return;                    // link goes down here
      if (r >= 15 && r < 20) begin
        repeat ($urandom_range(3, 1)) session.push_back('{OP_DATA, c, 8'($urandom)});
        session.push_back('{OP_DOWN, c, 8'($urandom)});
        return;
      end
      for (int k = 0; k < len; k++) session.push_back('{OP_DATA, c, 8'($urandom)});
    end
    if ($urandom_range(9) < 3) session.push_back('{OP_DOWN, c, 8'($urandom)});
  endfunction

  // Merges the new session into the backlog at random, keeping order per connection.
  function automatic void mix_session();
    stream_word_t mixed [$];
    while (backlog.size() != 0 || session.size() != 0) begin
      if (session.size() == 0 || (backlog.size() != 0 && $urandom_range(1) == 1))
        mixed.push_back(backlog.pop_front());
      else
        mixed.push_back(session.pop_front());
    end
    backlog = mixed;
  endfunction

  initial begin
    stream_word_t w;
    opcode_t      op;
    logic [7:0]   c;
    calm                 = 1'b0;
    rst                 <= 1'b1;
    stream.valid        <= 1'b0;
    stream.opcode       <= OP_DATA;
    stream.connection   <= 8'd0;
    stream.data_byte    <= 8'd0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed words. Ready stays low during the post-reset sweep; put_word waits.
    put_word(OP_DATA, 8'd5, 8'hA5);         // data on a waiting link: not open
    put_word(OP_OPEN_HS, 8'd0, 8'h00);
    put_word(OP_DATA, 8'd0, 8'h00);         // handshake matches index 0
    put_header(8'd0, 32'd0);                // zero length: empty frame
    put_word(OP_OPEN_OK, 8'd0, 8'h00);      // open on a live link: already open
    put_word(OP_OPEN_OK, 8'd255, 8'hFF);    // straight to header
    put_header(8'd255, 32'd2);
    put_word(OP_DATA, 8'd255, 8'hFF);
    put_word(OP_DATA, 8'd255, 8'h00);       // last byte of the frame
    put_word(OP_OPEN_HS, 8'd7, 8'h00);
    put_word(OP_DATA, 8'd7, 8'h08);         // wrong handshake byte: link down
    put_word(OP_DATA, 8'd7, 8'h07);         // data on a down link: not open
    put_word(OP_OPEN_HS, 8'd7, 8'h00);      // open on a down link: already open
    put_word(OP_OPEN_OK, 8'd9, 8'h00);
    put_header(8'd9, 32'hFF00_0000);        // top length byte set: too long
    spent[0]   = 1'b1;
    spent[7]   = 1'b1;
    spent[9]   = 1'b1;
    spent[255] = 1'b1;

    // Random part: interleaved sessions with a sprinkling of stray words.
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      calm = (n >= 300 && n < 650);
      // let everything in flight drain once before carrying on
      if (n == 900) begin
        stream.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      if (backlog.size() < BACKLOG_MIN) begin
        plan_session(fresh_connection());
        mix_session();
      end
      if ($urandom_range(99) < NOISE_PCT) begin
        c  = 8'($urandom);
        op = ($urandom_range(9) < 7) ? OP_DATA : opcode_t'($urandom_range(3, 1));
        if (op != OP_DATA) spent[c] = 1'b1;
        put_word(op, c, 8'($urandom));
      end else begin
        w = backlog.pop_front();
        put_word(w.op, w.conn, w.data);
      end
    end
    calm = 1'b0;

    // Drain: wait for every due result word, then a short tail.
    stream.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("handshake_length_prefix_deframer test passed");
    else
      $display("handshake_length_prefix_deframer test failed");
    $finish;
  end

endmodule

/* handshake_length_prefix_deframer.f */
sv/hlpd_pkg.sv
sv/hlpd_if.sv
sv/hlpd_state_mem.sv
sv/hlpd_update.sv
sv/handshake_length_prefix_deframer.sv
bench/deframe_checker.sv
bench/testbench.sv
